[sv/tpq_pkg.sv]
`default_nettype none

package tpq_pkg;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // field widths
    localparam int KEY_W  = 17;
    localparam int ID_W   = 8;
    localparam int SPD_W  = 8;
    localparam int WGT_W  = 16;
    localparam int CNT_OW = 5;

    // key base is 1000 / speed, 1000 takes 10 quotient bits
    localparam int QUOT_W = 10;
    localparam int DIV_CW = $clog2(QUOT_W + 1);
    localparam logic [QUOT_W-1:0] KEY_BASE = QUOT_W'(1000);

    localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [ID_W-1:0]   t_id;
    typedef logic [QUOT_W-1:0] t_quot;

    typedef struct packed {
        t_key key;
        t_id  id;
    } t_entry;

endpackage

`default_nettype wire

[sv/tpq_div.sv]
`default_nettype none

// Restoring divider: KEY_BASE / speed, one quotient bit per cycle.
module tpq_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [tpq_pkg::SPD_W-1:0]   i_speed,
    output logic                       o_done,
    output tpq_pkg::t_quot             o_quot
);

    logic                         r_busy;
    logic [tpq_pkg::DIV_CW-1:0]   r_cnt;
    logic [tpq_pkg::SPD_W-1:0]    r_den;
    logic [tpq_pkg::SPD_W-1:0]    r_rem;
    tpq_pkg::t_quot               r_num;
    logic                         r_done;

    logic [tpq_pkg::SPD_W:0]      w_trial;
    logic                         w_fit;

    // shift in the next dividend bit and try the subtraction
    assign w_trial = {r_rem, r_num[tpq_pkg::QUOT_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= tpq_pkg::DIV_CW'(tpq_pkg::QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == tpq_pkg::DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= (i_speed == '0) ? tpq_pkg::SPD_W'(1) : i_speed;
            r_rem <= '0;
            r_num <= tpq_pkg::KEY_BASE;
        end else if (r_busy) begin
            r_rem <= w_fit ? tpq_pkg::SPD_W'(w_trial - {1'b0, r_den})
                           : tpq_pkg::SPD_W'(w_trial);
            r_num <= {r_num[tpq_pkg::QUOT_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

[sv/timed_priority_queue.sv]
// Timed priority queue: bounded min-queue of 8-bit ids kept in ascending key
// order, key = 1000 / speed + weight (speed 0 counts as 1). Equal keys leave
// in arrival order.
// Input channel: i_valid / o_stall with i_operation (insert, pop, clear),
// i_entry_id, i_speed, i_weight. Output channel: o_valid / i_stall with
// o_popped_valid, o_popped_id, o_min_key, o_entry_count, o_overflow.
// Every accepted item yields exactly one result.
// One item is worked at a time; o_stall is high from acceptance until the
// result is loaded into the output register. Work per item:
//   insert: the 10-step divider, then one memory read and compare per
//           shifted entry
//   pop:    one read and one write of the store per entry moved
//   clear, full insert, empty pop: no store access, straight to the result
// The store is one memory with one write and one registered read port.
// Reset empties the queue and drops any pending result; the store itself
// is not cleared. While the receiver stalls, the result holds and the block
// finishes its next item, then waits until the output register frees up.
`default_nettype none

module timed_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire  [1:0]                  i_operation,
    input  wire  [tpq_pkg::ID_W-1:0]    i_entry_id,
    input  wire  [tpq_pkg::SPD_W-1:0]   i_speed,
    input  wire  [tpq_pkg::WGT_W-1:0]   i_weight,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic                        o_popped_valid,
    output logic [tpq_pkg::ID_W-1:0]    o_popped_id,
    output logic [tpq_pkg::KEY_W-1:0]   o_min_key,
    output logic [tpq_pkg::CNT_OW-1:0]  o_entry_count,
    output logic                        o_overflow
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIV     = 3'd1;
    localparam logic [2:0] S_INS_RD  = 3'd2;
    localparam logic [2:0] S_INS_CMP = 3'd3;
    localparam logic [2:0] S_POP_RD  = 3'd4;
    localparam logic [2:0] S_POP_WR  = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    tpq_pkg::t_entry       r_head, n_head;
    tpq_pkg::t_entry       r_new, n_new;
    logic [tpq_pkg::WGT_W-1:0] r_weight, n_weight;
    logic                  r_pv, n_pv;
    tpq_pkg::t_id          r_pid, n_pid;
    logic                  r_ovf, n_ovf;

    logic                  r_out_valid, n_out_valid;
    logic                  r_out_pv, n_out_pv;
    tpq_pkg::t_id          r_out_pid, n_out_pid;
    tpq_pkg::t_key         r_out_key, n_out_key;
    logic [CW-1:0]         r_out_cnt, n_out_cnt;
    logic                  r_out_ovf, n_out_ovf;

    tpq_pkg::t_entry       r_mem [QUEUE_DEPTH];
    tpq_pkg::t_entry       r_rd;
    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    logic [IW-1:0]         w_raddr;
    tpq_pkg::t_entry       w_wdata;

    logic                  w_accept;
    logic                  w_div_start;
    logic                  w_div_done;
    tpq_pkg::t_quot        w_quot;

    assign w_accept = i_valid && !o_stall;

    tpq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_speed (i_speed),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_head      = r_head;
        n_new       = r_new;
        n_weight    = r_weight;
        n_pv        = r_pv;
        n_pid       = r_pid;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && i_stall;
        n_out_pv    = r_out_pv;
        n_out_pid   = r_out_pid;
        n_out_key   = r_out_key;
        n_out_cnt   = r_out_cnt;
        n_out_ovf   = r_out_ovf;
        w_we        = 1'b0;
        w_waddr     = r_idx[IW-1:0];
        w_raddr     = r_idx[IW-1:0];
        w_wdata     = r_new;
        w_div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_pv    = 1'b0;
                    n_pid   = '0;
                    n_ovf   = 1'b0;
                    n_state = S_DONE;
                    unique case (i_operation)
                        tpq_pkg::OP_INSERT: begin
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_new.id    = i_entry_id;
                                n_weight    = i_weight;
                                w_div_start = 1'b1;
                                n_state     = S_DIV;
                            end
                        end
                        tpq_pkg::OP_POP: begin
                            if (r_count != '0) begin
                                n_pv  = 1'b1;
                                n_pid = r_head.id;
                                n_idx = CW'(1);
                                if (r_count == CW'(1)) begin
                                    n_count = '0;
                                end else begin
                                    n_state = S_POP_RD;
                                end
                            end
                        end
                        tpq_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // wait for the quotient, then form the key
            S_DIV: begin
                if (w_div_done) begin
                    n_new.key = tpq_pkg::KEY_W'(w_quot) + tpq_pkg::KEY_W'(r_weight);
                    n_idx     = r_count;
                    n_state   = S_INS_RD;
                end
            end

            // fetch the entry below the hole, or drop the new one at the head
            S_INS_RD: begin
                if (r_idx == '0) begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                    n_head  = r_new;
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end else begin
                    w_raddr = IW'(r_idx - CW'(1));
                    n_state = S_INS_CMP;
                end
            end

            // move a greater key up one slot, else place the new entry
            S_INS_CMP: begin
                w_we = 1'b1;
                if (r_rd.key > r_new.key) begin
                    w_wdata = r_rd;
                    n_idx   = r_idx - 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end
            end

            S_POP_RD: begin
                n_state = S_POP_WR;
            end

            // move one entry down; the entry landing in slot 0 is the new head
            S_POP_WR: begin
                w_we    = 1'b1;
                w_waddr = IW'(r_idx - CW'(1));
                w_wdata = r_rd;
                if (r_idx == CW'(1)) begin
                    n_head = r_rd;
                end
                if ((r_idx + CW'(1)) == r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_POP_RD;
                end
            end

            // load the result once the output register is free
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_pv    = r_pv;
                    n_out_pid   = r_pid;
                    n_out_key   = (r_count != '0) ? r_head.key : tpq_pkg::EMPTY_KEY;
                    n_out_cnt   = r_count;
                    n_out_ovf   = r_ovf;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_head    <= n_head;
        r_new     <= n_new;
        r_weight  <= n_weight;
        r_pv      <= n_pv;
        r_pid     <= n_pid;
        r_ovf     <= n_ovf;
        r_out_pv  <= n_out_pv;
        r_out_pid <= n_out_pid;
        r_out_key <= n_out_key;
        r_out_cnt <= n_out_cnt;
        r_out_ovf <= n_out_ovf;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_popped_valid = r_out_pv;
    assign o_popped_id    = r_out_pid;
    assign o_min_key      = r_out_key;
    assign o_entry_count  = tpq_pkg::CNT_OW'(r_out_cnt);
    assign o_overflow     = r_out_ovf;

    // checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("stored count above queue depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_popped_valid && o_overflow))
        else $error("pop and overflow in one result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (r_out_cnt == CW'(QUEUE_DEPTH)))
        else $error("overflow reported while queue not full");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out_cnt == '0) |-> (o_min_key == tpq_pkg::EMPTY_KEY))
        else $error("empty queue reports a minimum key");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count != CW'(QUEUE_DEPTH)))
        else $error("insert started into a full queue");

endmodule

`default_nettype wire

[bench/tb_timed_priority_queue.sv]
`default_nettype none

module tb_timed_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    // code 3 is unused by the block: it changes nothing and reports the state
    localparam logic [1:0] OP_NOP = 2'd3;
    // longest item is an insert ahead of 15 stored entries
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        logic                       popped_valid;
        tpq_pkg::t_id               popped_id;
        tpq_pkg::t_key              min_key;
        logic [tpq_pkg::CNT_OW-1:0] entry_count;
        logic                       overflow;
    } t_report;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [1:0]                 i_operation;
    logic [tpq_pkg::ID_W-1:0]   i_entry_id;
    logic [tpq_pkg::SPD_W-1:0]  i_speed;
    logic [tpq_pkg::WGT_W-1:0]  i_weight;
    logic                       o_valid;
    logic                       i_stall;
    logic                       o_popped_valid;
    logic [tpq_pkg::ID_W-1:0]   o_popped_id;
    logic [tpq_pkg::KEY_W-1:0]  o_min_key;
    logic [tpq_pkg::CNT_OW-1:0] o_entry_count;
    logic                       o_overflow;

    // entries in ascending key order, ties in arrival order
    tpq_pkg::t_entry queue_mirror[$];
    t_report         pending_reports[$];
    t_report         due_report;
    int              mismatch_count = 0;
    bit              tx_calm = 0;
    bit              rx_calm = 0;

    timed_priority_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_entry_id     (i_entry_id),
        .i_speed        (i_speed),
        .i_weight       (i_weight),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_popped_valid (o_popped_valid),
        .o_popped_id    (o_popped_id),
        .o_min_key      (o_min_key),
        .o_entry_count  (o_entry_count),
        .o_overflow     (o_overflow)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // apply one operation to the mirror and return the report it yields
    function automatic t_report queue_mirror_step(logic [1:0] op, tpq_pkg::t_id id,
                                                  logic [tpq_pkg::SPD_W-1:0] spd,
                                                  logic [tpq_pkg::WGT_W-1:0] wgt);
        t_report                   rep;
        tpq_pkg::t_entry           ent;
        int                        pos;
        logic [tpq_pkg::SPD_W-1:0] divisor;
        rep = '0;
        case (op)
            tpq_pkg::OP_INSERT: begin
                // zero speed counts as one
                divisor = (spd == '0) ? tpq_pkg::SPD_W'(1) : spd;
                ent.key = tpq_pkg::t_key'(tpq_pkg::KEY_BASE / divisor)
                        + tpq_pkg::t_key'(wgt);
                ent.id  = id;
                if (queue_mirror.size() >= DEPTH) begin
                    rep.overflow = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < queue_mirror.size() && queue_mirror[pos].key <= ent.key)
                        pos++;
                    queue_mirror.insert(pos, ent);
                end
            end
            tpq_pkg::OP_POP: begin
                if (queue_mirror.size() > 0) begin
                    ent = queue_mirror.pop_front();
                    rep.popped_valid = 1'b1;
                    rep.popped_id    = ent.id;
                end
            end
            tpq_pkg::OP_CLEAR: begin
                queue_mirror.delete();
            end
            default: ;
        endcase
        rep.entry_count = tpq_pkg::CNT_OW'(queue_mirror.size());
        rep.min_key     = (queue_mirror.size() > 0) ? queue_mirror[0].key
                                                    : tpq_pkg::EMPTY_KEY;
        return rep;
    endfunction

    // hold the item until taken, record its report, then maybe pause
    task automatic send_item(logic [1:0] op, tpq_pkg::t_id id,
                             logic [tpq_pkg::SPD_W-1:0] spd,
                             logic [tpq_pkg::WGT_W-1:0] wgt);
        int gap;
        i_valid     <= 1'b1;
        i_operation <= op;
        i_entry_id  <= id;
        i_speed     <= spd;
        i_weight    <= wgt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_reports.push_back(queue_mirror_step(op, id, spd, wgt));
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drop valid and hold off until every report has come back
    task automatic wait_for_reports();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    function automatic void compare_field(string name, logic [31:0] want,
                                          logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // check each taken result against the oldest report
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_reports.size() == 0) begin
                $error("result with no item outstanding");
                mismatch_count++;
            end else begin
                due_report = pending_reports.pop_front();
                compare_field("popped_valid", 32'(due_report.popped_valid),
                              32'(o_popped_valid));
                compare_field("popped_id", 32'(due_report.popped_id), 32'(o_popped_id));
                compare_field("min_key", 32'(due_report.min_key), 32'(o_min_key));
                compare_field("entry_count", 32'(due_report.entry_count),
                              32'(o_entry_count));
                compare_field("overflow", 32'(due_report.overflow), 32'(o_overflow));
            end
        end
    end

    // receiver: free runs with stall bursts between them
    initial begin
        i_stall = 1'b0;
        forever begin
            int busy;
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            busy = pick_gap();
            if (busy > 0 && !rx_calm) begin
                i_stall <= 1'b1;
                repeat (busy) @(posedge i_clk);
            end
        end
    end

    // pop, clear and the unused code on an empty queue
    task automatic test_empty_queue();
        send_item(tpq_pkg::OP_POP, 8'hA5, 8'd7, 16'd9);
        send_item(tpq_pkg::OP_CLEAR, 8'h5A, 8'd0, 16'hFFFF);
        send_item(OP_NOP, 8'hFF, 8'hFF, 16'h0000);
    endtask

    // key extremes, zero speed and ties that must leave in arrival order
    task automatic test_keys_and_ties();
        send_item(tpq_pkg::OP_INSERT, 8'd10, 8'd1, 16'd0);
        send_item(tpq_pkg::OP_INSERT, 8'd11, 8'd2, 16'd500);
        send_item(tpq_pkg::OP_INSERT, 8'd255, 8'd0, 16'hFFFF);
        send_item(tpq_pkg::OP_INSERT, 8'd12, 8'd4, 16'd750);
        send_item(tpq_pkg::OP_INSERT, 8'd0, 8'd255, 16'd0);
        send_item(tpq_pkg::OP_INSERT, 8'd1, 8'd3, 16'd0);
        send_item(OP_NOP, 8'd0, 8'd0, 16'd0);
        repeat (7) send_item(tpq_pkg::OP_POP, 8'($urandom_range(0, 255)), 8'd1, 16'd0);
    endtask

    // clear a queue that holds entries
    task automatic test_clear();
        send_item(tpq_pkg::OP_INSERT, 8'd40, 8'd9, 16'd12);
        send_item(tpq_pkg::OP_INSERT, 8'd41, 8'd8, 16'd3);
        send_item(tpq_pkg::OP_CLEAR, 8'd42, 8'd1, 16'd1);
        send_item(tpq_pkg::OP_POP, 8'd43, 8'd1, 16'd1);
    endtask

    // fill to capacity, overflow, then work a full and draining queue
    task automatic test_overflow();
        repeat (DEPTH)
            send_item(tpq_pkg::OP_INSERT, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 16'($urandom_range(0, 300)));
        send_item(tpq_pkg::OP_INSERT, 8'd255, 8'd255, 16'd0);
        send_item(tpq_pkg::OP_INSERT, 8'd0, 8'd0, 16'hFFFF);
        send_item(OP_NOP, 8'd3, 8'd3, 16'd3);
        repeat (8) send_item(tpq_pkg::OP_POP, 8'd0, 8'd1, 16'd0);
        send_item(tpq_pkg::OP_INSERT, 8'd77, 8'd5, 16'd100);
        send_item(tpq_pkg::OP_CLEAR, 8'd0, 8'd1, 16'd0);
    endtask

    // phases that fill, drain or mix, with keys that often collide
    task automatic test_random(int n_items);
        int                        done;
        int                        ins_pct;
        int                        pop_pct;
        int                        r;
        logic [1:0]                op;
        logic [tpq_pkg::SPD_W-1:0] spd;
        logic [tpq_pkg::WGT_W-1:0] wgt;
        done = 0;
        while (done < n_items) begin
            case ($urandom_range(0, 3))
                0:       begin ins_pct = 80; pop_pct = 15; end
                1:       begin ins_pct = 20; pop_pct = 75; end
                default: begin ins_pct = 50; pop_pct = 45; end
            endcase
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(20, 120)) begin
                r = $urandom_range(0, 99);
                if (r < ins_pct)
                    op = tpq_pkg::OP_INSERT;
                else if (r < ins_pct + pop_pct)
                    op = tpq_pkg::OP_POP;
                else if (r < 98)
                    op = OP_NOP;
                else
                    op = tpq_pkg::OP_CLEAR;
                if ($urandom_range(0, 2) == 0) begin
                    spd = tpq_pkg::SPD_W'(1 << $urandom_range(0, 3));
                    wgt = tpq_pkg::WGT_W'($urandom_range(0, 3));
                end else begin
                    spd = tpq_pkg::SPD_W'($urandom_range(0, 255));
                    wgt = tpq_pkg::WGT_W'($urandom_range(0, 65535));
                end
                send_item(op, 8'($urandom_range(0, 255)), spd, wgt);
                done++;
            end
            if ($urandom_range(0, 5) == 0) wait_for_reports();
        end
        tx_calm = 0;
        rx_calm = 0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = tpq_pkg::OP_INSERT;
        i_entry_id  = '0;
        i_speed     = 8'd1;
        i_weight    = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_keys_and_ties();
        wait_for_reports();
        test_clear();
        test_overflow();
        wait_for_reports();
        test_random(1650);
        wait_for_reports();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
